@@ sv/pcp_pkg.sv @@
`default_nettype none

package pcp_pkg;

    // Fraction bits of corrections, unit vector and mass shares
    localparam int FRAC_BITS = 16;
    // Quotient width of unit vector and share divisions (value <= 1.0)
    localparam int UW = FRAC_BITS + 1;
    // Dividend width of those divisions: 31-bit magnitude shifted up
    localparam int DNW = 31 + FRAC_BITS;
    // Penetration times share
    localparam int PW = 31 + UW;
    // Per-particle step length after dropping fraction bits
    localparam int TW = PW - FRAC_BITS;
    // Correction magnitude before saturation
    localparam int MW = TW + UW - FRAC_BITS;
    // Root bits of the 64-bit squared distance
    localparam int SQ_STAGES = 32;

    typedef struct packed {
        logic [15:0] first_index;
        logic [15:0] second_index;
        logic        stable_mode;
        logic [31:0] first_x;
        logic [31:0] first_y;
        logic [31:0] second_x;
        logic [31:0] second_y;
        logic [23:0] first_inv_mass;
        logic [23:0] second_inv_mass;
        logic [7:0]  first_count;
        logic [7:0]  second_count;
    } t_in;

    typedef struct packed {
        logic [15:0] out_first_index;
        logic [15:0] out_second_index;
        logic [31:0] first_dx;
        logic [31:0] first_dy;
        logic [31:0] second_dx;
        logic [31:0] second_dy;
        logic        corrected;
        logic        apply_to_positions;
    } t_out;

endpackage

`default_nettype wire

@@ sv/pcp_isqrt.sv @@
`default_nettype none

// Pipelined integer square root, one root bit per stage.
module pcp_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [pcp_pkg::SQ_STAGES-1:0] o_root
);
    import pcp_pkg::*;

    logic [33:0] w_rem  [SQ_STAGES+1];
    logic [31:0] w_root [SQ_STAGES+1];
    logic [63:0] w_val  [SQ_STAGES+1];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_val[0]  = i_val;

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
        logic [35:0] trial;
        logic [35:0] cand;
        logic        ge;
        logic [33:0] r_rem;
        logic [31:0] r_root;
        logic [63:0] r_val;

        assign trial = {w_rem[k], w_val[k][63:62]};
        assign cand  = {2'b00, w_root[k], 2'b01};
        assign ge    = trial >= cand;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= ge ? 34'(trial - cand) : trial[33:0];
                r_root <= {w_root[k][30:0], ge};
                r_val  <= {w_val[k][61:0], 2'b00};
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_val[k+1]  = r_val;
    end

    assign o_root = w_root[SQ_STAGES];

endmodule

`default_nettype wire

@@ sv/pcp_udiv.sv @@
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit in UW bits; otherwise the result is meaningless.
module pcp_udiv (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [pcp_pkg::DNW-1:0]  i_num,
    input  logic [31:0]              i_den,
    output logic [pcp_pkg::UW-1:0]   o_quo
);
    import pcp_pkg::*;

    logic [31:0]   w_rem [UW+1];
    logic [UW-1:0] w_lo  [UW+1];
    logic [31:0]   w_den [UW+1];

    assign w_rem[0] = 32'(i_num[DNW-1:UW]);
    assign w_lo[0]  = i_num[UW-1:0];
    assign w_den[0] = i_den;

    for (genvar k = 0; k < UW; k++) begin : g_st
        logic [32:0]   trial;
        logic          ge;
        logic [31:0]   r_rem;
        logic [UW-1:0] r_lo;
        logic [31:0]   r_den;

        assign trial = {w_rem[k], w_lo[k][UW-1]};
        assign ge    = trial >= {1'b0, w_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= ge ? 32'(trial - {1'b0, w_den[k]}) : trial[31:0];
                r_lo  <= {w_lo[k][UW-2:0], ge};
                r_den <= w_den[k];
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_lo[k+1]  = r_lo;
        assign w_den[k+1] = r_den;
    end

    assign o_quo = w_lo[UW];

endmodule

`default_nettype wire

@@ sv/pcp_cdiv.sv @@
`default_nettype none

// Pipelined divide by an 8-bit count, one quotient bit per stage.
module pcp_cdiv (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [pcp_pkg::TW-1:0]  i_num,
    input  logic [7:0]              i_den,
    output logic [pcp_pkg::TW-1:0]  o_quo
);
    import pcp_pkg::*;

    logic [7:0]    w_rem [TW+1];
    logic [TW-1:0] w_lo  [TW+1];
    logic [7:0]    w_den [TW+1];

    assign w_rem[0] = '0;
    assign w_lo[0]  = i_num;
    assign w_den[0] = i_den;

    for (genvar k = 0; k < TW; k++) begin : g_st
        logic [8:0]    trial;
        logic          ge;
        logic [7:0]    r_rem;
        logic [TW-1:0] r_lo;
        logic [7:0]    r_den;

        assign trial = {w_rem[k], w_lo[k][TW-1]};
        assign ge    = trial >= {1'b0, w_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= ge ? 8'(trial - {1'b0, w_den[k]}) : trial[7:0];
                r_lo  <= {w_lo[k][TW-2:0], ge};
                r_den <= w_den[k];
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_lo[k+1]  = r_lo;
        assign w_den[k+1] = r_den;
    end

    assign o_quo = w_lo[TW];

endmodule

`default_nettype wire

@@ sv/particle_contact_projection_top.sv @@
`default_nettype none

// Channel   Direction  Handshake                     Payload
// in        input      i_in_valid / o_in_ready       i_in_data  (pcp_pkg::t_in)
// out       output     o_out_valid / i_out_ready     o_out_data (pcp_pkg::t_out)
// cfg       input      i_cfg_we (no wait)            i_cfg_wdata (particle diameter)
//
// One transaction per cycle sustained while the output buffer is not full.
// From input to output the data passes the root pipeline (32 stages), the
// unit/share dividers (FRAC_BITS+1 stages), the count divider (32 stages),
// six arithmetic stages and the output buffer.
// Reset (synchronous, active low) clears all valid bits, empties the output
// buffer and sets the diameter to 1.0.
// The pipeline advances as one; it halts only while the two-entry output
// buffer is full, so one finished result may wait while intake goes on.

module particle_contact_projection_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [30:0]     i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pcp_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output pcp_pkg::t_out   o_out_data
);
    import pcp_pkg::*;

    localparam logic [MW-1:0] MAG_NEG_LIM = MW'(32'h8000_0000);
    localparam logic [MW-1:0] MAG_POS_LIM = MW'(32'h7FFF_FFFF);

    // Sideband through the root pipeline
    typedef struct packed {
        logic [15:0] idx1;
        logic [15:0] idx2;
        logic        stable;
        logic        nx;
        logic        ny;
        logic        ok;
        logic [30:0] ax;
        logic [30:0] ay;
        logic [23:0] w1;
        logic [23:0] w2;
        logic [7:0]  c1;
        logic [7:0]  c2;
    } t_ctx1;

    // Sideband through the unit/share dividers
    typedef struct packed {
        logic [15:0] idx1;
        logic [15:0] idx2;
        logic        stable;
        logic        nx;
        logic        ny;
        logic        ok;
        logic [30:0] pen;
        logic [7:0]  c1;
        logic [7:0]  c2;
    } t_ctx2;

    // Sideband through the count divider
    typedef struct packed {
        logic [15:0]   idx1;
        logic [15:0]   idx2;
        logic          stable;
        logic          nx;
        logic          ny;
        logic          ok;
        logic [UW-1:0] ux;
        logic [UW-1:0] uy;
    } t_ctx3;

    function automatic logic [31:0] sat_enc(input logic [MW-1:0] mag, input logic neg);
        logic [MW-1:0] neg_mag;
        neg_mag = '0 - mag;
        if (neg) begin
            if (mag > MAG_NEG_LIM) begin
                return 32'h8000_0000;
            end
            return neg_mag[31:0];
        end
        if (mag > MAG_POS_LIM) begin
            return 32'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [30:0] r_diam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diam <= 31'd65536;
        end else if (i_cfg_we) begin
            r_diam <= i_cfg_wdata;
        end
    end

    // Global advance: the whole pipeline moves unless the output buffer is full
    logic [1:0] r_cnt;
    logic       w_en;
    assign w_en       = (r_cnt != 2'd2);
    assign o_in_ready = w_en;

    // ---------------------------------------------------------------
    // Stage 1: differences, magnitudes, range check
    // ---------------------------------------------------------------
    logic [32:0] w_dx, w_dy, w_adx, w_ady;
    t_ctx1       n_s1;
    t_ctx1       r_s1;
    logic        r_s1_v;

    assign w_dx  = {i_in_data.first_x[31], i_in_data.first_x}
                 - {i_in_data.second_x[31], i_in_data.second_x};
    assign w_dy  = {i_in_data.first_y[31], i_in_data.first_y}
                 - {i_in_data.second_y[31], i_in_data.second_y};
    assign w_adx = w_dx[32] ? (33'd0 - w_dx) : w_dx;
    assign w_ady = w_dy[32] ? (33'd0 - w_dy) : w_dy;

    always_comb begin
        n_s1.idx1   = i_in_data.first_index;
        n_s1.idx2   = i_in_data.second_index;
        n_s1.stable = i_in_data.stable_mode;
        n_s1.nx     = w_dx[32];
        n_s1.ny     = w_dy[32];
        // magnitudes of 2^31 or more are always beyond any diameter
        n_s1.ok     = ((i_in_data.first_inv_mass | i_in_data.second_inv_mass) != '0)
                   && (w_adx[32:31] == 2'b00) && (w_ady[32:31] == 2'b00);
        n_s1.ax     = w_adx[30:0];
        n_s1.ay     = w_ady[30:0];
        n_s1.w1     = i_in_data.first_inv_mass;
        n_s1.w2     = i_in_data.second_inv_mass;
        n_s1.c1     = i_in_data.first_count;
        n_s1.c2     = i_in_data.second_count;
    end

    // ---------------------------------------------------------------
    // Stage 2: squares. Stage 3: sum of squares.
    // ---------------------------------------------------------------
    t_ctx1       r_s2, r_s3;
    logic        r_s2_v, r_s3_v;
    logic [61:0] r_sqx, r_sqy;
    logic [62:0] r_sum;

    // ---------------------------------------------------------------
    // Root pipeline
    // ---------------------------------------------------------------
    logic [SQ_STAGES-1:0] w_dist;
    t_ctx1                r_sq_ctx [SQ_STAGES];
    logic [SQ_STAGES-1:0] r_sq_v;
    t_ctx1                w_c1;

    pcp_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  ({1'b0, r_sum}),
        .o_root (w_dist)
    );

    assign w_c1 = r_sq_ctx[SQ_STAGES-1];

    // ---------------------------------------------------------------
    // Stage 4: overlap test, penetration, divider operands
    // ---------------------------------------------------------------
    t_ctx2          r_s4;
    logic           r_s4_v;
    logic [DNW-1:0] r_num_ux, r_num_uy, r_num_s1, r_num_s2;
    logic [31:0]    r_dist, r_wsum;

    // Divider pipelines: unit vector and mass shares
    logic [UW-1:0] w_ux, w_uy, w_s1, w_s2;
    t_ctx2         r_dv_ctx [UW];
    logic [UW-1:0] r_dv_v;
    t_ctx2         w_c2;

    pcp_udiv u_div_ux (.i_clk(i_clk), .i_en(w_en), .i_num(r_num_ux),
                       .i_den(r_dist), .o_quo(w_ux));
    pcp_udiv u_div_uy (.i_clk(i_clk), .i_en(w_en), .i_num(r_num_uy),
                       .i_den(r_dist), .o_quo(w_uy));
    pcp_udiv u_div_s1 (.i_clk(i_clk), .i_en(w_en), .i_num(r_num_s1),
                       .i_den(r_wsum), .o_quo(w_s1));
    pcp_udiv u_div_s2 (.i_clk(i_clk), .i_en(w_en), .i_num(r_num_s2),
                       .i_den(r_wsum), .o_quo(w_s2));

    assign w_c2 = r_dv_ctx[UW-1];

    // ---------------------------------------------------------------
    // Stage 5: penetration times share
    // ---------------------------------------------------------------
    t_ctx3         r_s5;
    logic          r_s5_v;
    logic [PW-1:0] r_p1, r_p2;
    logic [7:0]    r_s5_c1, r_s5_c2;

    // Count divider pipelines
    logic [TW-1:0] w_t1, w_t2;
    t_ctx3         r_cd_ctx [TW];
    logic [TW-1:0] r_cd_v;
    t_ctx3         w_c3;

    pcp_cdiv u_cdiv1 (.i_clk(i_clk), .i_en(w_en), .i_num(r_p1[PW-1:FRAC_BITS]),
                      .i_den(r_s5_c1), .o_quo(w_t1));
    pcp_cdiv u_cdiv2 (.i_clk(i_clk), .i_en(w_en), .i_num(r_p2[PW-1:FRAC_BITS]),
                      .i_den(r_s5_c2), .o_quo(w_t2));

    assign w_c3 = r_cd_ctx[TW-1];

    // ---------------------------------------------------------------
    // Stage 6: step length times unit vector, masked when no contact
    // ---------------------------------------------------------------
    logic [TW+UW-1:0] w_p1x, w_p1y, w_p2x, w_p2y;
    t_ctx3            r_s6;
    logic             r_s6_v;
    logic [MW-1:0]    r_m1x, r_m1y, r_m2x, r_m2y;

    assign w_p1x = w_t1 * w_c3.ux;
    assign w_p1y = w_t1 * w_c3.uy;
    assign w_p2x = w_t2 * w_c3.ux;
    assign w_p2y = w_t2 * w_c3.uy;

    // Payload registers of all stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1  <= n_s1;

            r_s2  <= r_s1;
            r_sqx <= r_s1.ax * r_s1.ax;
            r_sqy <= r_s1.ay * r_s1.ay;

            r_s3  <= r_s2;
            r_sum <= {1'b0, r_sqx} + {1'b0, r_sqy};

            r_sq_ctx[0] <= r_s3;
            for (int k = 1; k < SQ_STAGES; k++) begin
                r_sq_ctx[k] <= r_sq_ctx[k-1];
            end

            r_s4.idx1   <= w_c1.idx1;
            r_s4.idx2   <= w_c1.idx2;
            r_s4.stable <= w_c1.stable;
            r_s4.nx     <= w_c1.nx;
            r_s4.ny     <= w_c1.ny;
            // coincident particles give no correction
            r_s4.ok     <= w_c1.ok && (w_dist != '0) && (w_dist < {1'b0, r_diam});
            r_s4.pen    <= 31'({1'b0, r_diam} - w_dist);
            r_s4.c1     <= (w_c1.c1 == 8'd0) ? 8'd1 : w_c1.c1;
            r_s4.c2     <= (w_c1.c2 == 8'd0) ? 8'd1 : w_c1.c2;
            r_num_ux    <= {w_c1.ax, {FRAC_BITS{1'b0}}};
            r_num_uy    <= {w_c1.ay, {FRAC_BITS{1'b0}}};
            r_num_s1    <= DNW'({w_c1.w1, {FRAC_BITS{1'b0}}});
            r_num_s2    <= DNW'({w_c1.w2, {FRAC_BITS{1'b0}}});
            r_dist      <= w_dist;
            r_wsum      <= 32'({1'b0, w_c1.w1} + {1'b0, w_c1.w2});

            r_dv_ctx[0] <= r_s4;
            for (int k = 1; k < UW; k++) begin
                r_dv_ctx[k] <= r_dv_ctx[k-1];
            end

            r_s5.idx1   <= w_c2.idx1;
            r_s5.idx2   <= w_c2.idx2;
            r_s5.stable <= w_c2.stable;
            r_s5.nx     <= w_c2.nx;
            r_s5.ny     <= w_c2.ny;
            r_s5.ok     <= w_c2.ok;
            r_s5.ux     <= w_ux;
            r_s5.uy     <= w_uy;
            r_p1        <= w_c2.pen * w_s1;
            r_p2        <= w_c2.pen * w_s2;
            r_s5_c1     <= w_c2.c1;
            r_s5_c2     <= w_c2.c2;

            r_cd_ctx[0] <= r_s5;
            for (int k = 1; k < TW; k++) begin
                r_cd_ctx[k] <= r_cd_ctx[k-1];
            end

            r_s6  <= w_c3;
            r_m1x <= w_c3.ok ? w_p1x[TW+UW-1:FRAC_BITS] : '0;
            r_m1y <= w_c3.ok ? w_p1y[TW+UW-1:FRAC_BITS] : '0;
            r_m2x <= w_c3.ok ? w_p2x[TW+UW-1:FRAC_BITS] : '0;
            r_m2y <= w_c3.ok ? w_p2y[TW+UW-1:FRAC_BITS] : '0;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_sq_v <= '0;
            r_s4_v <= 1'b0;
            r_dv_v <= '0;
            r_s5_v <= 1'b0;
            r_cd_v <= '0;
            r_s6_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_sq_v <= {r_sq_v[SQ_STAGES-2:0], r_s3_v};
            r_s4_v <= r_sq_v[SQ_STAGES-1];
            r_dv_v <= {r_dv_v[UW-2:0], r_s4_v};
            r_s5_v <= r_dv_v[UW-1];
            r_cd_v <= {r_cd_v[TW-2:0], r_s5_v};
            r_s6_v <= r_cd_v[TW-1];
        end
    end

    // ---------------------------------------------------------------
    // Saturation and result assembly
    // ---------------------------------------------------------------
    t_out w_res;

    always_comb begin
        w_res.out_first_index    = r_s6.idx1;
        w_res.out_second_index   = r_s6.idx2;
        w_res.first_dx           = sat_enc(r_m1x, r_s6.nx);
        w_res.first_dy           = sat_enc(r_m1y, r_s6.ny);
        w_res.second_dx          = sat_enc(r_m2x, !r_s6.nx);
        w_res.second_dy          = sat_enc(r_m2y, !r_s6.ny);
        w_res.corrected          = ((r_m1x | r_m1y | r_m2x | r_m2y) != '0);
        w_res.apply_to_positions = r_s6.stable;
    end

    // ---------------------------------------------------------------
    // Two-entry output buffer; entry 0 drives the port
    // ---------------------------------------------------------------
    t_out       r_buf0, r_buf1;
    t_out       n_buf0, n_buf1;
    logic [1:0] n_cnt;
    logic       w_push, w_pop;

    assign w_push = w_en && r_s6_v;
    assign w_pop  = o_out_valid && i_out_ready;

    always_comb begin
        n_buf0 = r_buf0;
        n_buf1 = r_buf1;
        n_cnt  = r_cnt;
        if (w_pop) begin
            n_buf0 = r_buf1;
            n_cnt  = 2'(n_cnt - 2'd1);
        end
        if (w_push) begin
            if (n_cnt == 2'd0) begin
                n_buf0 = w_res;
            end else begin
                n_buf1 = w_res;
            end
            n_cnt = 2'(n_cnt + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf0 <= n_buf0;
        r_buf1 <= n_buf1;
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_buf0;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_corr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.corrected |->
            (o_out_data.first_dx | o_out_data.first_dy |
             o_out_data.second_dx | o_out_data.second_dy) != 32'd0)
        else $error("corrected result with all-zero deltas");

    a_uncorr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.corrected |->
            (o_out_data.first_dx | o_out_data.first_dy |
             o_out_data.second_dx | o_out_data.second_dy) == 32'd0)
        else $error("uncorrected result with nonzero deltas");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            r_cnt == 2'($past(r_cnt) + 2'($past(w_push)) - 2'($past(w_pop))))
        else $error("output buffer count lost or repeated a transaction");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer overfilled");

endmodule

`default_nettype wire
